// ===== hw/rtl/swlp_pkg.sv =====
// ----------------------------------------------------------------------------
// swlp_pkg: shared definitions for the sliding window percentile unit
// Field widths, register map codes, reset values, rank arithmetic constants
// and the control bundle broadcast to the sorted cell chain.
// ----------------------------------------------------------------------------
package swlp_pkg;

	// payload field widths
	localparam int IN_W   = 24;
	localparam int THR_W  = 24;
	localparam int PCT_W  = 7;
	localparam int FILL_W = 11;
	localparam int VAL_W  = 24;

	// default sizing
	localparam int DEF_WINDOW      = 1024;
	localparam int DEF_SAMPLE_BITS = 24;

	// register map
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;
	localparam int REG_LSB = 2;
	localparam logic REG_THR = 1'b0;
	localparam logic REG_PCT = 1'b1;

	// register reset values
	localparam logic [THR_W-1:0] THR_RESET = 24'd100000;
	localparam logic [PCT_W-1:0] PCT_RESET = 7'd99;
	localparam logic [PCT_W-1:0] PCT_MIN   = 7'd1;
	localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;

	// rank = (n*p + 99) / 100 - 1, the divide done as a reciprocal multiply
	// numerator stays below 2^19 for windows up to 4096 entries
	localparam int NUM_W       = 19;
	localparam int RANK_ROUND  = 99;
	localparam int RECIP_W     = 20;
	localparam int RECIP_100   = 671089;
	localparam int RECIP_SHIFT = 26;

	// width of one rank select group
	localparam int SEL_GROUP = 32;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic en;   // update the chain this cycle
		logic rm;   // window full: drop the oldest value
	} upd_ctrl_t;

endpackage

// ===== hw/rtl/swlp_in_if.sv =====
// ----------------------------------------------------------------------------
// swlp_in_if: sample channel
// Carries one latency sample per transaction with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface swlp_in_if;
	logic                      valid;
	logic                      ready;
	logic [swlp_pkg::IN_W-1:0] latency_us;

	modport source (output valid, output latency_us, input ready);
	modport sink   (input valid, input latency_us, output ready);
endinterface

// ===== hw/rtl/swlp_out_if.sv =====
// ----------------------------------------------------------------------------
// swlp_out_if: result channel
// Carries the percentile value, threshold flag and window fill per transaction.
// ----------------------------------------------------------------------------
interface swlp_out_if;
	logic                        valid;
	logic                        ready;
	logic [swlp_pkg::VAL_W-1:0]  percentile_value;
	logic                        over_threshold;
	logic [swlp_pkg::FILL_W-1:0] window_fill;

	modport source (output valid, output percentile_value, output over_threshold,
		output window_fill, input ready);
	modport sink   (input valid, input percentile_value, input over_threshold,
		input window_fill, output ready);
endinterface

// ===== hw/rtl/swlp_cell.sv =====
// ----------------------------------------------------------------------------
// swlp_cell: one slot of the sorted sample chain
// Holds one sample. On an update it drops the oldest value by taking its right
// neighbour, then makes room for the new sample by taking its left neighbour.
// Only neighbour values are looked at, so all cells of the chain update together.
// ----------------------------------------------------------------------------
module swlp_cell #(
	parameter int DW    = swlp_pkg::DEF_SAMPLE_BITS,
	parameter int CNT_W = $clog2(swlp_pkg::DEF_WINDOW + 1),
	parameter int POS   = 0
) (
	input  logic                clk,
	input  swlp_pkg::upd_ctrl_t ctl,
	input  logic [DW-1:0]       sample,
	input  logic [DW-1:0]       old_val,
	input  logic [CNT_W-1:0]    count_m,
	input  logic [DW-1:0]       nxt_val,
	input  logic [DW-1:0]       prev_m,
	input  logic                prev_gm,
	output logic [DW-1:0]       val,
	output logic [DW-1:0]       link_m,
	output logic                link_gm
);

	logic [DW-1:0] val_q;
	logic          rm_here;
	logic          gt_own;
	logic          gt_nxt;
	logic          in_use;

	// removal: every slot from the first copy of the oldest value shifts left
	assign rm_here = ctl.rm && (val_q >= old_val);
	assign link_m  = rm_here ? nxt_val : val_q;

	// compares against the new sample run in parallel with the removal select
	assign gt_own  = val_q > sample;
	assign gt_nxt  = nxt_val > sample;
	assign in_use  = CNT_W'(POS) < count_m;
	assign link_gm = !in_use || (rm_here ? gt_nxt : gt_own);

	// insertion: slots above the new sample shift right, the first takes it
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (!link_gm)
				val_q <= link_m;
			else if (!prev_gm)
				val_q <= sample;
			else
				val_q <= prev_m;
		end
	end

	assign val = val_q;

endmodule

// ===== hw/rtl/swlp_sel.sv =====
// ----------------------------------------------------------------------------
// swlp_sel: rank select over the cell chain
// Two-level select: a registered pick within each group of cells, then a
// pick among the groups that feeds the output register of the top level.
// ----------------------------------------------------------------------------
module swlp_sel #(
	parameter int N  = swlp_pkg::DEF_WINDOW,
	parameter int DW = swlp_pkg::DEF_SAMPLE_BITS,
	localparam int IDX_W = $clog2(N)
) (
	input  logic             clk,
	input  logic             en,
	input  logic [IDX_W-1:0] rank,
	input  logic [DW-1:0]    vals [N],
	output logic [DW-1:0]    value
);

	localparam int GRP  = (N < swlp_pkg::SEL_GROUP) ? (1 << $clog2(N)) : swlp_pkg::SEL_GROUP;
	localparam int NGRP = (N + GRP - 1) / GRP;
	localparam int LO_W = $clog2(GRP);

	logic [DW-1:0]   pad    [NGRP][GRP];
	logic [DW-1:0]   grp_s1 [NGRP];
	logic [LO_W-1:0] lo;

	assign lo = rank[LO_W-1:0];

	// arrange the chain into groups, unused slots padded
	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		for (genvar k = 0; k < GRP; k++) begin : g_slot
			if (g * GRP + k < N) begin : g_used
				assign pad[g][k] = vals[g * GRP + k];
			end else begin : g_pad
				assign pad[g][k] = '0;
			end
		end
	end

	// first level: pick within every group
	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < NGRP; g++)
				grp_s1[g] <= pad[g][lo];
		end
	end

	// second level: pick the group
	if (NGRP == 1) begin : g_one
		assign value = grp_s1[0];
	end else begin : g_many
		localparam int HI_W = $clog2(NGRP);
		logic [HI_W-1:0] hi;
		assign hi    = HI_W'(rank >> LO_W);
		assign value = grp_s1[hi];
	end

endmodule

// ===== hw/rtl/sliding_window_latency_percentile_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_window_latency_percentile_unit: latency percentile over a window
// Keeps the latest WINDOW_SIZE samples as a sorted chain of cells plus a
// history memory in arrival order, and reports the sample at the configured
// percentile rank together with a threshold flag and the window fill.
//
//   channel   role   handshake        payload
//   samples   sink   valid/ready      latency_us
//   results   source valid/ready      percentile_value, over_threshold, window_fill
//   apb       slave  psel/penable     threshold at 0x0, percentile at 0x4
//
// steps: accept, rank product, chain update, then the two levels of the rank
//   select; the next sample is accepted only after the last step completes
// reset: control clears, registers load reset values; no clearing pass is needed
// stalls: a result waiting on results.ready holds the last select stage and
//   the next sample waits until it moves to the output register
// ----------------------------------------------------------------------------
module sliding_window_latency_percentile_unit #(
	parameter int WINDOW_SIZE = swlp_pkg::DEF_WINDOW,
	parameter int SAMPLE_BITS = swlp_pkg::DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	swlp_in_if.sink                       samples,
	swlp_out_if.source                    results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [swlp_pkg::APB_AW-1:0]   paddr,
	input  logic [swlp_pkg::APB_DW-1:0]   pwdata,
	output logic [swlp_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	localparam int IDX_W = $clog2(WINDOW_SIZE);
	localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
	localparam int SB    = SAMPLE_BITS;
	localparam int IN_W  = swlp_pkg::IN_W;
	localparam int CMP_W = (SB > IN_W) ? SB : IN_W;
	localparam int QP_W  = swlp_pkg::NUM_W + swlp_pkg::RECIP_W;
	localparam logic [IN_W-1:0] SAT_LIM =
		(SB >= IN_W) ? {IN_W{1'b1}} : IN_W'((64'd1 << SB) - 64'd1);

	typedef enum logic [2:0] {ST_IDLE, ST_PROD, ST_UPD, ST_SEL1, ST_SEL2} state_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              fill_q;
	logic [IDX_W-1:0]              wr_ptr_q;
	logic                          res_valid_q;
	logic [swlp_pkg::THR_W-1:0]    thr_q;
	logic [swlp_pkg::PCT_W-1:0]    pct_q;

	logic [SB-1:0]                 sample_q;
	logic                          ovr_q;
	logic [CNT_W-1:0]              n_q;
	logic [swlp_pkg::PCT_W-1:0]    p_q;
	logic [swlp_pkg::NUM_W-1:0]    prod_q;
	logic [IDX_W-1:0]              rank_q;
	logic [SB-1:0]                 old_q;
	logic [swlp_pkg::VAL_W-1:0]    res_val_q;
	logic                          res_ovr_q;
	logic [swlp_pkg::FILL_W-1:0]   res_fill_q;

	logic [SB-1:0]                 hist_mem [WINDOW_SIZE];

	logic                          acc;
	logic                          cfg_wr;
	logic                          full;
	logic                          out_free;
	logic [SB-1:0]                 sample_d;
	logic [swlp_pkg::PCT_W-1:0]    p_d;
	logic [QP_W-1:0]               qprod;
	logic [CNT_W-1:0]              count_m;
	swlp_pkg::upd_ctrl_t           ctl;
	logic [SB-1:0]                 sel_val;

	logic [SB-1:0]                 cell_val [WINDOW_SIZE];
	logic [SB-1:0]                 link_m   [WINDOW_SIZE];
	logic                          link_gm  [WINDOW_SIZE];

	// handshakes
	assign acc      = samples.valid && samples.ready;
	assign samples.ready = (state_q == ST_IDLE);
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign out_free = !res_valid_q || results.ready;

	// register read back
	assign prdata = (paddr[swlp_pkg::REG_LSB] == swlp_pkg::REG_PCT) ?
		swlp_pkg::APB_DW'(pct_q) : swlp_pkg::APB_DW'(thr_q);

	// saturate the sample and clamp the percentile
	assign sample_d = (samples.latency_us > SAT_LIM) ? {SB{1'b1}} : SB'(samples.latency_us);
	assign p_d = (pct_q < swlp_pkg::PCT_MIN) ? swlp_pkg::PCT_MIN :
		(pct_q > swlp_pkg::PCT_MAX) ? swlp_pkg::PCT_MAX : pct_q;

	// window state seen by the chain
	assign full    = (fill_q == CNT_W'(WINDOW_SIZE));
	assign count_m = full ? CNT_W'(WINDOW_SIZE - 1) : fill_q;
	assign ctl.en  = (state_q == ST_UPD);
	assign ctl.rm  = full;

	// divide by 100 as a reciprocal multiply
	assign qprod = QP_W'(prod_q) * QP_W'(swlp_pkg::RECIP_100);

	// sequencer, window counters, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			wr_ptr_q    <= '0;
			res_valid_q <= 1'b0;
			thr_q       <= swlp_pkg::THR_RESET;
			pct_q       <= swlp_pkg::PCT_RESET;
		end else begin
			if (cfg_wr) begin
				case (paddr[swlp_pkg::REG_LSB])
					swlp_pkg::REG_THR: thr_q <= pwdata[swlp_pkg::THR_W-1:0];
					swlp_pkg::REG_PCT: pct_q <= pwdata[swlp_pkg::PCT_W-1:0];
					default: ;
				endcase
			end
			// output valid: loaded from the last select stage, cleared when taken
			if (state_q == ST_SEL2 && out_free)
				res_valid_q <= 1'b1;
			else if (results.ready)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc)
						state_q <= ST_PROD;
				end
				ST_PROD: state_q <= ST_UPD;
				ST_UPD: begin
					if (!full)
						fill_q <= fill_q + CNT_W'(1);
					if (wr_ptr_q == IDX_W'(WINDOW_SIZE - 1))
						wr_ptr_q <= '0;
					else
						wr_ptr_q <= wr_ptr_q + IDX_W'(1);
					state_q <= ST_SEL1;
				end
				ST_SEL1: state_q <= ST_SEL2;
				ST_SEL2: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// transaction payload through the steps
	always_ff @(posedge clk) begin
		if (acc) begin
			sample_q <= sample_d;
			ovr_q    <= CMP_W'(sample_d) > CMP_W'(thr_q);
			n_q      <= full ? fill_q : fill_q + CNT_W'(1);
			p_q      <= p_d;
		end
		if (state_q == ST_PROD)
			prod_q <= swlp_pkg::NUM_W'(n_q) * swlp_pkg::NUM_W'(p_q) +
				swlp_pkg::NUM_W'(swlp_pkg::RANK_ROUND);
		if (state_q == ST_UPD)
			rank_q <= IDX_W'((qprod >> swlp_pkg::RECIP_SHIFT) - QP_W'(1));
		if (state_q == ST_SEL2 && out_free) begin
			res_val_q  <= swlp_pkg::VAL_W'(sel_val);
			res_ovr_q  <= ovr_q;
			res_fill_q <= swlp_pkg::FILL_W'(fill_q);
		end
	end

	// history in arrival order: oldest read at accept, new sample written on update
	always_ff @(posedge clk) begin
		if (acc)
			old_q <= hist_mem[wr_ptr_q];
		if (state_q == ST_UPD)
			hist_mem[wr_ptr_q] <= sample_q;
	end

	// sorted chain of cells
	for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
		logic [SB-1:0] nxt_v;
		logic [SB-1:0] prv_m;
		logic          prv_gm;
		if (i == WINDOW_SIZE - 1) begin : g_last
			assign nxt_v = '0;
		end else begin : g_mid
			assign nxt_v = cell_val[i + 1];
		end
		if (i == 0) begin : g_first
			assign prv_m  = '0;
			assign prv_gm = 1'b0;
		end else begin : g_rest
			assign prv_m  = link_m[i - 1];
			assign prv_gm = link_gm[i - 1];
		end
		swlp_cell #(
			.DW    (SB),
			.CNT_W (CNT_W),
			.POS   (i)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.sample  (sample_q),
			.old_val (old_q),
			.count_m (count_m),
			.nxt_val (nxt_v),
			.prev_m  (prv_m),
			.prev_gm (prv_gm),
			.val     (cell_val[i]),
			.link_m  (link_m[i]),
			.link_gm (link_gm[i])
		);
	end

	// rank select
	swlp_sel #(
		.N  (WINDOW_SIZE),
		.DW (SB)
	) u_sel (
		.clk   (clk),
		.en    (state_q == ST_SEL1),
		.rank  (rank_q),
		.vals  (cell_val),
		.value (sel_val)
	);

	// result channel
	assign results.valid            = res_valid_q;
	assign results.percentile_value = res_val_q;
	assign results.over_threshold   = res_ovr_q;
	assign results.window_fill      = res_fill_q;

	// fill never runs past the window
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW_SIZE))
		else $error("window fill beyond window size");

	// until the window is full the write pointer tracks the fill
	a_ptr_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> CNT_W'(wr_ptr_q) == fill_q)
		else $error("write pointer out of step with fill");

	// the selected rank lies inside the filled part of the chain
	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEL1 |-> CNT_W'(rank_q) < fill_q)
		else $error("rank outside the window");

	// after a sample is taken the sequencer steps through rank product, chain update, first select
	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q == ST_PROD ##1 state_q == ST_UPD ##1 state_q == ST_SEL1)
		else $error("sequencer skipped a step");

endmodule

// ===== verif/sliding_window_latency_percentile_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sliding_window_latency_percentile_unit_tb: self-checking bench
// Streams latency samples through the unit and compares every result
// transaction with its expectation: typed values for the opening probes,
// a behavioural sorted-window predictor for the rest. It steps through
// several threshold and percentile settings, including the clamped ones,
// and carries the window well past its full depth to cover eviction. Random
// idle bursts on both channels and one long receiver hold-off are applied.
// ----------------------------------------------------------------------------
module sliding_window_latency_percentile_unit_tb;

	localparam int WIN          = swlp_pkg::DEF_WINDOW;
	localparam int PHASES       = 7;
	localparam int PHASE_ITEMS  = 240;
	localparam int SHOW_LIMIT   = 10;
	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 80;
	localparam int HOLD_AFTER   = 300;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [swlp_pkg::VAL_W-1:0]  value;
		logic                        over;
		logic [swlp_pkg::FILL_W-1:0] fill;
	} pct_result_t;

	typedef struct {
		logic [swlp_pkg::IN_W-1:0] latency;
		bit                        known;
		pct_result_t               result;
	} probe_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [swlp_pkg::APB_AW-1:0] paddr;
	logic [swlp_pkg::APB_DW-1:0] pwdata;
	logic [swlp_pkg::APB_DW-1:0] prdata;
	logic pready;

	swlp_in_if  sample_ch ();
	swlp_out_if result_ch ();

	sliding_window_latency_percentile_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.results (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #2 clk = ~clk;

	// predictor state: arrival-order history and a sorted copy
	logic [swlp_pkg::IN_W-1:0]  window_hist [WIN];
	logic [swlp_pkg::IN_W-1:0]  window_sorted [$];
	int unsigned                window_head;
	int unsigned                window_count;
	int unsigned                window_wraps;
	logic [swlp_pkg::THR_W-1:0] thr_cfg;
	logic [swlp_pkg::PCT_W-1:0] pct_cfg;

	pct_result_t expected_percentiles [$];
	pct_result_t got_result;
	pct_result_t want_result;

	int  mismatches;
	int  samples_sent;
	int  results_seen;
	int  settings_used;
	bit  steady;
	bit  hold_done;
	int  quiet_cycles;

	// directed probes; only the opening rows are obvious by hand
	probe_row_t probe_rows [20] = '{
		'{24'h000000, 1'b1, '{24'h000000, 1'b0, 11'd1}},
		'{24'hFFFFFF, 1'b1, '{24'hFFFFFF, 1'b1, 11'd2}},
		'{24'd100000, 1'b1, '{24'hFFFFFF, 1'b0, 11'd3}},
		'{24'd100001, 1'b1, '{24'hFFFFFF, 1'b1, 11'd4}},
		'{24'd99999,  1'b0, '{24'h0, 1'b0, 11'd0}},
		'{24'h000001, 1'b0, '{24'h0, 1'b0, 11'd0}},
		'{24'hFFFFFE, 1'b0, '{24'h0, 1'b0, 11'd0}},
		'{24'h800000, 1'b0, '{24'h0, 1'b0, 11'd0}},
		'{24'h7FFFFF, 1'b0, '{24'h0, 1'b0, 11'd0}},
		'{24'h555555, 1'b0, '{24'h0, 1'b0, 11'd0}},
		'{24'hAAAAAA, 1'b0, '{24'h0, 1'b0, 11'd0}},
		'{24'h000000, 1'b0, '{24'h0, 1'b0, 11'd0}},
		'{24'h000000, 1'b0, '{24'h0, 1'b0, 11'd0}},
		'{24'hFFFFFF, 1'b0, '{24'h0, 1'b0, 11'd0}},
		'{24'd100000, 1'b0, '{24'h0, 1'b0, 11'd0}},
		'{24'h000001, 1'b0, '{24'h0, 1'b0, 11'd0}},
		'{24'h123456, 1'b0, '{24'h0, 1'b0, 11'd0}},
		'{24'hFEDCBA, 1'b0, '{24'h0, 1'b0, 11'd0}},
		'{24'h00FFFF, 1'b0, '{24'h0, 1'b0, 11'd0}},
		'{24'hFF0000, 1'b0, '{24'h0, 1'b0, 11'd0}}
	};

	// insert the new sample, evict the oldest when full, pick the ranked entry
	task automatic predict_percentile(input logic [swlp_pkg::IN_W-1:0] s,
			output pct_result_t r);
		int unsigned i;
		int unsigned p;
		int unsigned rank;
		if (window_count == WIN) begin
			for (i = 0; i < window_sorted.size(); i++) begin
				if (window_sorted[i] == window_hist[window_head]) begin
					window_sorted.delete(i);
					break;
				end
			end
			window_hist[window_head] = s;
			window_head = (window_head + 1) % WIN;
			if (window_head == 0)
				window_wraps++;
		end else begin
			window_hist[(window_head + window_count) % WIN] = s;
			window_count++;
		end
		i = 0;
		while (i < window_sorted.size() && window_sorted[i] <= s)
			i++;
		window_sorted.insert(i, s);
		p = pct_cfg;
		if (p < swlp_pkg::PCT_MIN)
			p = swlp_pkg::PCT_MIN;
		if (p > swlp_pkg::PCT_MAX)
			p = swlp_pkg::PCT_MAX;
		rank = (window_count * p + swlp_pkg::RANK_ROUND) / 100 - 1;
		if (rank >= window_count)
			rank = window_count - 1;
		r.value = window_sorted[rank];
		r.over  = (s > thr_cfg);
		r.fill  = swlp_pkg::FILL_W'(window_count);
	endtask

	// well-spread values mixed with ties, extremes and threshold neighbours
	function automatic logic [swlp_pkg::IN_W-1:0] rand_latency(
			input logic [swlp_pkg::THR_W-1:0] thr);
		int near;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return swlp_pkg::IN_W'($urandom_range(0, 15));
			4, 5: begin
				near = int'(thr) + int'($urandom_range(0, 2)) - 1;
				if (near < 0)
					near = 0;
				if (near > 24'hFFFFFF)
					near = 24'hFFFFFF;
				return swlp_pkg::IN_W'(near);
			end
			default: return swlp_pkg::IN_W'($urandom());
		endcase
	endfunction

	// apb read with readback compare over the register's width
	task automatic read_register(input logic sel, input logic [swlp_pkg::APB_DW-1:0] want);
		logic [swlp_pkg::APB_DW-1:0] rd;
		logic ok;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= swlp_pkg::APB_AW'(sel) << swlp_pkg::REG_LSB;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (sel == swlp_pkg::REG_THR)
			ok = (rd[swlp_pkg::THR_W-1:0] == want[swlp_pkg::THR_W-1:0]);
		else
			ok = (rd[swlp_pkg::PCT_W-1:0] == want[swlp_pkg::PCT_W-1:0]);
		if (!ok) begin
			if (mismatches < SHOW_LIMIT)
				$display("register %0d read back %h, expected %h", sel, rd, want);
			mismatches++;
		end
	endtask

	// apb write, shadow update, then readback
	task automatic write_register(input logic sel, input logic [swlp_pkg::APB_DW-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= swlp_pkg::APB_AW'(sel) << swlp_pkg::REG_LSB;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (sel == swlp_pkg::REG_THR)
			thr_cfg = data[swlp_pkg::THR_W-1:0];
		else
			pct_cfg = data[swlp_pkg::PCT_W-1:0];
		read_register(sel, data);
	endtask

	// offer one sample, optionally after an idle burst; called at a falling edge
	task automatic send_sample(input logic [swlp_pkg::IN_W-1:0] s, input bit known,
			input pct_result_t typed);
		pct_result_t r;
		if (!steady && $urandom_range(0, 4) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		sample_ch.valid      <= 1'b1;
		sample_ch.latency_us <= s;
		do @(posedge clk); while (!sample_ch.ready);
		predict_percentile(s, r);
		expected_percentiles.insert(expected_percentiles.size(), known ? typed : r);
		samples_sent++;
		@(negedge clk);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		while (expected_percentiles.size() != 0)
			@(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	// result channel ready: random bursts, one long hold-off
	int hold_left;
	int gap_left;
	initial begin
		result_ch.ready = 1'b0;
		hold_left = 0;
		gap_left  = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (!arst_n)
				result_ch.ready <= 1'b0;
			else if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				result_ch.ready <= 1'b0;
			end else if (!steady && $urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(0, 5);
				result_ch.ready <= 1'b0;
			end else
				result_ch.ready <= 1'b1;
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got_result.value = result_ch.percentile_value;
			got_result.over  = result_ch.over_threshold;
			got_result.fill  = result_ch.window_fill;
			if (expected_percentiles.size() == 0) begin
				if (mismatches < SHOW_LIMIT)
					$display("result %0d arrived with nothing expected: value %h over %0b fill %0d",
						results_seen, got_result.value, got_result.over, got_result.fill);
				mismatches++;
			end else begin
				want_result = expected_percentiles.pop_front();
				if (got_result.value !== want_result.value
						|| got_result.over !== want_result.over
						|| got_result.fill !== want_result.fill) begin
					if (mismatches < SHOW_LIMIT)
						$display("result %0d: expected value %h over %0b fill %0d, got value %h over %0b fill %0d",
							results_seen, want_result.value, want_result.over, want_result.fill,
							got_result.value, got_result.over, got_result.fill);
					mismatches++;
				end
			end
			results_seen++;
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (sample_ch.valid && sample_ch.ready)
				|| (result_ch.valid && result_ch.ready))
			quiet_cycles = 0;
		else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
				$display("** sliding_window_latency_percentile_unit: FAILED **");
				$finish;
			end
		end
	end

	// main sequence
	logic [swlp_pkg::THR_W-1:0] phase_thr [PHASES];
	logic [swlp_pkg::PCT_W-1:0] phase_pct [PHASES];
	initial begin
		int ph;
		int k;
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		sample_ch.valid      = 1'b0;
		sample_ch.latency_us = '0;
		window_head          = 0;
		window_count         = 0;
		window_wraps         = 0;
		mismatches           = 0;
		samples_sent         = 0;
		results_seen         = 0;
		settings_used        = 1;
		steady               = 1'b0;
		thr_cfg              = swlp_pkg::THR_RESET;
		pct_cfg              = swlp_pkg::PCT_RESET;

		// threshold extremes and every clamp of the percentile
		phase_thr = '{24'h000000, 24'hFFFFFF, swlp_pkg::THR_W'($urandom()),
			swlp_pkg::THR_W'($urandom()), swlp_pkg::THR_W'($urandom_range(0, 200000)),
			swlp_pkg::THR_W'($urandom()), swlp_pkg::THR_RESET};
		phase_pct = '{swlp_pkg::PCT_MIN, swlp_pkg::PCT_MAX, 7'd0, 7'd127, 7'd50,
			swlp_pkg::PCT_W'($urandom_range(1, 127)), swlp_pkg::PCT_RESET};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values of both registers
		read_register(swlp_pkg::REG_THR, swlp_pkg::APB_DW'(swlp_pkg::THR_RESET));
		read_register(swlp_pkg::REG_PCT, swlp_pkg::APB_DW'(swlp_pkg::PCT_RESET));

		// directed probes at reset settings
		foreach (probe_rows[i])
			send_sample(probe_rows[i].latency, probe_rows[i].known, probe_rows[i].result);
		drain_results();

		// random traffic, one register setting per phase, the last one steady
		for (ph = 0; ph < PHASES; ph++) begin
			write_register(swlp_pkg::REG_THR, swlp_pkg::APB_DW'(phase_thr[ph]));
			write_register(swlp_pkg::REG_PCT, swlp_pkg::APB_DW'(phase_pct[ph]));
			settings_used++;
			steady = (ph == PHASES - 1);
			for (k = 0; k < PHASE_ITEMS; k++)
				send_sample(rand_latency(thr_cfg), 1'b0, '0);
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d samples under %0d register settings, %0d results compared",
			samples_sent, settings_used, results_seen);
		$display("window reached %0d entries and wrapped %0d times; one %0d-cycle receiver hold",
			window_count, window_wraps, HOLD_CYCLES);
		if (mismatches == 0 && expected_percentiles.size() == 0)
			$display("** sliding_window_latency_percentile_unit: PASSED **");
		else
			$display("** sliding_window_latency_percentile_unit: FAILED **");
		$finish;
	end

endmodule
